// ----- rtl/core/assert_macros.svh -----
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, checking off during reset
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// condition that must never be true outside reset
`define ASSERT_NEVER(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(cond)) else $error(msg);

`endif

// ----- rtl/core/clut_pkg.sv -----
package clut_pkg;

   localparam int PAL_DEPTH = 256;
   localparam int PAL_AW    = $clog2(PAL_DEPTH);
   localparam int ENTRY_W   = 16;
   localparam int PIXEL_W   = 32;
   localparam int BYTE_W    = 8;
   localparam int NIB_W     = 4;
   localparam int CH_W      = 5;
   localparam int CH_OUT_W  = 8;
   localparam int MODE_W    = 2;
   localparam int STP_BIT   = 15;

   typedef enum logic [MODE_W-1:0] {
      MODE_4BIT  = 2'd0,
      MODE_8BIT  = 2'd1,
      MODE_BLANK = 2'd2
   } mode_type;

   typedef enum logic {
      REQ_PALETTE = 1'b0,
      REQ_TEXEL   = 1'b1
   } req_kind_type;

   localparam logic [CH_OUT_W-1:0] ALPHA_CLEAR  = 8'h00;
   localparam logic [CH_OUT_W-1:0] ALPHA_OPAQUE = 8'hff;
   localparam logic [CH_OUT_W-1:0] ALPHA_SEMI   = CH_OUT_W'(255 / 4);
   localparam logic [PIXEL_W-1:0]  BLANK_PIXEL  = 32'hffff_ffff;

   // floor(c * 255 / 31) for every 5-bit channel value
   localparam logic [CH_OUT_W-1:0] WIDEN5 [32] = '{
      8'd0,   8'd8,   8'd16,  8'd24,  8'd32,  8'd41,  8'd49,  8'd57,
      8'd65,  8'd74,  8'd82,  8'd90,  8'd98,  8'd106, 8'd115, 8'd123,
      8'd131, 8'd139, 8'd148, 8'd156, 8'd164, 8'd172, 8'd180, 8'd189,
      8'd197, 8'd205, 8'd213, 8'd222, 8'd230, 8'd238, 8'd246, 8'd255
   };

   function automatic logic [CH_OUT_W-1:0] widen5(logic [CH_W-1:0] c);
      return WIDEN5[c];
   endfunction

   // bgr555 entry to rgba8888
   function automatic logic [PIXEL_W-1:0] decode_entry(logic [ENTRY_W-1:0] e);
      logic [CH_OUT_W-1:0] r;
      logic [CH_OUT_W-1:0] g;
      logic [CH_OUT_W-1:0] b;
      logic [CH_OUT_W-1:0] a;
      logic                black;
      r     = widen5(e[CH_W-1:0]);
      g     = widen5(e[2*CH_W-1:CH_W]);
      b     = widen5(e[3*CH_W-1:2*CH_W]);
      black = (e[3*CH_W-1:0] == '0);
      if (!e[STP_BIT]) begin
         a = black ? ALPHA_CLEAR : ALPHA_OPAQUE;
      end else begin
         a = black ? ALPHA_OPAQUE : ALPHA_SEMI;
      end
      return {r, g, b, a};
   endfunction

endpackage

// ----- rtl/core/clut_if.sv -----
interface clut_req_if;
   logic                             valid;
   logic                             ready;
   logic                             req_type;
   logic [clut_pkg::PAL_AW-1:0]      palette_index;
   logic [clut_pkg::ENTRY_W-1:0]     palette_entry;
   logic [clut_pkg::BYTE_W-1:0]      texel_byte;

   modport source (output valid, req_type, palette_index, palette_entry, texel_byte,
                   input ready);
   modport sink   (input valid, req_type, palette_index, palette_entry, texel_byte,
                   output ready);
endinterface

interface clut_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [clut_pkg::PIXEL_W-1:0]     pixel_rgba;
   logic                             last_of_item;

   modport source (output valid, pixel_rgba, last_of_item, input ready);
   modport sink   (input valid, pixel_rgba, last_of_item, output ready);
endinterface

interface clut_csr_if;
   logic                             valid;
   logic                             ready;
   logic [clut_pkg::MODE_W-1:0]      texel_mode;

   modport source (output valid, texel_mode, input ready);
   modport sink   (input valid, texel_mode, output ready);
endinterface

// ----- rtl/core/clut_texel_to_rgba.sv -----
// pipeline: palette read data and stage 1 registers, then the output register
// throughput: 8-bit and blank modes take one item per cycle unless output stalls;
//   4-bit mode takes no item during its second read of the single-port palette
// reset: synchronous, clears texel_mode to 4-bit and empties the pipeline;
//   palette contents stay undefined until written, no clearing pass
`include "assert_macros.svh"

module clut_texel_to_rgba (
   input logic          clock,
   input logic          reset,
   clut_req_if.sink     req_chan,
   clut_rsp_if.source   rsp_chan,
   clut_csr_if.sink     csr_chan
);
   import clut_pkg::*;

   logic [MODE_W-1:0]  texel_mode_ff;
   logic [MODE_W-1:0]  texel_mode_in;

   logic [ENTRY_W-1:0] pal_mem [PAL_DEPTH];
   logic [ENTRY_W-1:0] rd_data_ff;

   logic               pend_ff;
   logic               pend_in;
   logic [NIB_W-1:0]   pend_idx_ff;
   logic [NIB_W-1:0]   pend_idx_in;

   logic               s1_valid_ff;
   logic               s1_valid_in;
   logic               s1_last_ff;
   logic               s1_last_in;
   logic               s1_blank_ff;
   logic               s1_blank_in;

   logic               out_valid_ff;
   logic               out_valid_in;
   logic [PIXEL_W-1:0] out_pixel_ff;
   logic [PIXEL_W-1:0] out_pixel_in;
   logic               out_last_ff;
   logic               out_last_in;

   logic               s2_load;
   logic               s1_load;
   logic               req_acc;
   logic               wr_en;
   logic               texel_acc;
   logic               rd_en;
   logic [PAL_AW-1:0]  rd_addr;

   assign s2_load        = !out_valid_ff || rsp_chan.ready;
   assign s1_load        = !s1_valid_ff || s2_load;
   assign req_chan.ready = !pend_ff && s1_load;
   assign req_acc        = req_chan.valid && req_chan.ready;
   assign wr_en          = req_acc && (req_chan.req_type == REQ_PALETTE);
   assign texel_acc      = req_acc && (req_chan.req_type == REQ_TEXEL);

   assign csr_chan.ready = 1'b1;
   assign texel_mode_in  = csr_chan.valid ? csr_chan.texel_mode : texel_mode_ff;

   // read issue and stage 1 next values
   always_comb begin
      rd_en       = 1'b0;
      rd_addr     = '0;
      pend_in     = pend_ff;
      pend_idx_in = pend_idx_ff;
      s1_valid_in = s1_valid_ff;
      s1_last_in  = s1_last_ff;
      s1_blank_in = s1_blank_ff;
      if (s1_load) begin
         s1_valid_in = 1'b0;
      end
      if (pend_ff && s1_load) begin
         // high nibble of a 4-bit byte
         rd_en       = 1'b1;
         rd_addr     = {{(PAL_AW-NIB_W){1'b0}}, pend_idx_ff};
         pend_in     = 1'b0;
         s1_valid_in = 1'b1;
         s1_last_in  = 1'b1;
         s1_blank_in = 1'b0;
      end else if (texel_acc) begin
         case (mode_type'(texel_mode_ff))
            MODE_4BIT: begin
               rd_en       = 1'b1;
               rd_addr     = {{(PAL_AW-NIB_W){1'b0}}, req_chan.texel_byte[NIB_W-1:0]};
               pend_in     = 1'b1;
               pend_idx_in = req_chan.texel_byte[BYTE_W-1:NIB_W];
               s1_valid_in = 1'b1;
               s1_last_in  = 1'b0;
               s1_blank_in = 1'b0;
            end
            MODE_8BIT: begin
               rd_en       = 1'b1;
               rd_addr     = req_chan.texel_byte[PAL_AW-1:0];
               s1_valid_in = 1'b1;
               s1_last_in  = 1'b1;
               s1_blank_in = 1'b0;
            end
            MODE_BLANK: begin
               s1_valid_in = 1'b1;
               s1_last_in  = 1'b1;
               s1_blank_in = 1'b1;
            end
            default: begin
               // unused mode: item dropped without results
               s1_valid_in = 1'b0;
            end
         endcase
      end
   end

   // output register next values
   always_comb begin
      out_valid_in = out_valid_ff;
      out_pixel_in = out_pixel_ff;
      out_last_in  = out_last_ff;
      if (s2_load) begin
         out_valid_in = s1_valid_ff;
         out_pixel_in = s1_blank_ff ? BLANK_PIXEL : decode_entry(rd_data_ff);
         out_last_in  = s1_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         texel_mode_ff <= MODE_4BIT;
         pend_ff       <= 1'b0;
         s1_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         texel_mode_ff <= texel_mode_in;
         pend_ff       <= pend_in;
         s1_valid_ff   <= s1_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_idx_ff  <= pend_idx_in;
      s1_last_ff   <= s1_last_in;
      s1_blank_ff  <= s1_blank_in;
      out_pixel_ff <= out_pixel_in;
      out_last_ff  <= out_last_in;
   end

   // palette memory, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         pal_mem[req_chan.palette_index] <= req_chan.palette_entry;
      end
      if (rd_en) begin
         rd_data_ff <= pal_mem[rd_addr];
      end
   end

   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.pixel_rgba   = out_pixel_ff;
   assign rsp_chan.last_of_item = out_last_ff;

   `ASSERT_NEVER(a_no_accept_when_pend, pend_ff && req_chan.ready, "item accepted during second read")
   `ASSERT_CLK(a_4bit_sets_pend, texel_acc && (texel_mode_ff == MODE_4BIT) |=> pend_ff, "4-bit item did not queue its high nibble")
   `ASSERT_CLK(a_first_pixel_has_pend, s1_valid_ff && !s1_last_ff |-> pend_ff, "first pixel in stage 1 without pending high nibble")

endmodule
